[sv/pld_pkg.sv]
// pld_pkg: shared constants, request types and sequencer states for the
// predictive LZ image decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pld_pkg;

    // History ring depth (power of two) and derived pointer width
    localparam int HISTORY_DEPTH = 4096;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);

    // Offset registers
    localparam int OFFSET_W      = 13;
    localparam int NUM_OFFSETS   = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int ADDR_EXT_W    = (PTR_W > OFFSET_W) ? PTR_W : OFFSET_W;

    // Control byte layout
    localparam int BYTE_W        = 8;
    localparam int LEN_SHIFT     = 3;
    localparam int LEN_W         = BYTE_W - LEN_SHIFT;
    localparam int MODE_W        = LEN_SHIFT;
    localparam logic [MODE_W-1:0] MODE_LITERAL = '0;
    localparam logic [MODE_W-1:0] MODE_MASK    = MODE_W'(7);

    // Byte counter
    localparam int COUNT_W = 24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              image_start;
        logic              input_last;
    } in_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               image_done;
        logic [COUNT_W-1:0] bytes_written;
        logic               run_last;
    } out_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_LIT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[sv/pld_in_if.sv]
// pld_in_if: valid/ready channel carrying compressed stream requests.
// Depends on pld_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pld_in_if;
    logic             valid;
    logic             ready;
    pld_pkg::in_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/pld_out_if.sv]
// pld_out_if: valid/ready channel carrying decoded byte and done requests.
// Depends on pld_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pld_out_if;
    logic              valid;
    logic              ready;
    pld_pkg::out_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/predictive_lz_image_decoder.sv]
// Predictive LZ image decoder, top level.
// Depends on pld_pkg, pld_in_if, pld_out_if.
//
// Usage:
//   comp   : compressed stream in, one byte per request, with image_start
//            (restarts the decoder) and input_last (ends the image after it).
//   decomp : decoded requests out. Each is a decoded byte (byte_valid) or the
//            single done request (image_done, bytes_written). run_last marks
//            the final request caused by one input byte.
//   cfg_*  : write port for the seven per-mode history offsets (index 0 is
//            mode 1). Write only while the decoder is idle.
// Sequencing: one input byte is worked on at a time; comp.ready is high only in
//   the idle state. A literal data byte passes through ST_LIT; a copy control
//   byte steps through ST_COPY_RD and ST_COPY_WR for each copied byte (a
//   registered read of the single-port history RAM followed by its write-back),
//   and the done request adds ST_DONE.
// Output: a one-entry output register decouples the receiver; while it is
//   full and decomp.ready is low the sequencer holds, nothing is lost.
// Reset: sequencer idle, output empty, image state cleared, offsets -1.
//   The history RAM is not cleared; reads outside the current image's
//   decoded range return 0 from the byte count check.
`timescale 1ns / 1ps
`default_nettype none
module predictive_lz_image_decoder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [pld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pld_pkg::OFFSET_W-1:0]   cfg_data,
    pld_in_if.sink                              comp,
    pld_out_if.source                           decomp
);

    // Offset registers
    logic [pld_pkg::OFFSET_W-1:0] offset_reg [pld_pkg::NUM_OFFSETS];

    // Sequencer and image state
    pld_pkg::state_t               state_reg, state_next;
    logic [pld_pkg::PTR_W-1:0]     wp_reg, wp_next;
    logic [pld_pkg::COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [pld_pkg::LEN_W-1:0]     lit_reg, lit_next;
    logic                          fin_reg, fin_next;
    logic [pld_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [pld_pkg::MODE_W-1:0]    mode_reg, mode_next;
    logic                          pend_reg, pend_next;   // done request follows
    logic [pld_pkg::BYTE_W-1:0]    byte_reg, byte_next;   // literal byte
    logic                          zero_reg, zero_next;   // copy source reads 0

    // Output register
    logic                          out_valid_reg, out_valid_next;
    pld_pkg::out_req_t             out_data_reg, out_data_next;

    // History RAM
    logic [pld_pkg::BYTE_W-1:0]    history_mem [pld_pkg::HISTORY_DEPTH];
    logic [pld_pkg::BYTE_W-1:0]    rd_data_reg;
    logic                          rd_en;
    logic                          mem_we;
    logic [pld_pkg::PTR_W-1:0]     rd_addr;
    logic [pld_pkg::BYTE_W-1:0]    emit_byte;

    // Copy address path
    logic [pld_pkg::OFFSET_W-1:0]  raw_off;
    logic [pld_pkg::OFFSET_W-1:0]  back_dist;
    logic [pld_pkg::MODE_W-1:0]    off_idx;

    // Request decode
    logic                          accept;
    logic                          out_free;
    logic                          start;
    logic                          last;
    logic                          fin_eff;
    logic [pld_pkg::LEN_W-1:0]     lit_eff;
    logic [pld_pkg::LEN_W-1:0]     ctl_len;
    logic [pld_pkg::MODE_W-1:0]    ctl_mode;
    logic                          last_byte;

    assign comp.ready   = (state_reg == pld_pkg::ST_IDLE);
    assign accept       = comp.valid && comp.ready;
    assign out_free     = !out_valid_reg || decomp.ready;
    assign decomp.valid = out_valid_reg;
    assign decomp.data  = out_data_reg;

    assign start    = comp.data.image_start;
    assign last     = comp.data.input_last;
    assign fin_eff  = start ? 1'b0 : fin_reg;
    assign lit_eff  = start ? '0 : lit_reg;
    assign ctl_len  = comp.data.in_byte[pld_pkg::BYTE_W-1:pld_pkg::LEN_SHIFT];
    assign ctl_mode = comp.data.in_byte[pld_pkg::MODE_W-1:0] & pld_pkg::MODE_MASK;

    // Mode n uses offset register n-1. Offset is a negative 13-bit value;
    // back_dist = -offset, and the ring address is wp - back_dist.
    assign off_idx   = mode_reg - pld_pkg::MODE_W'(1);
    assign raw_off   = offset_reg[off_idx];
    assign back_dist = ~raw_off + pld_pkg::OFFSET_W'(1);
    assign rd_addr   = pld_pkg::PTR_W'(pld_pkg::ADDR_EXT_W'(wp_reg)
                                       - pld_pkg::ADDR_EXT_W'(back_dist));

    assign emit_byte = (state_reg == pld_pkg::ST_LIT) ? byte_reg
                     : (zero_reg ? '0 : rd_data_reg);
    assign last_byte = (state_reg == pld_pkg::ST_LIT)
                     || (len_reg == pld_pkg::LEN_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        lit_next       = lit_reg;
        fin_next       = fin_reg;
        len_next       = len_reg;
        mode_next      = mode_reg;
        pend_next      = pend_reg;
        byte_next      = byte_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !decomp.ready;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        mem_we         = 1'b0;

        unique case (state_reg)
            pld_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (start)
                    begin
                        wp_next  = '0;
                        cnt_next = '0;
                        lit_next = '0;
                        fin_next = 1'b0;
                    end
                    pend_next = last;
                    if (!fin_eff)
                    begin
                        if (lit_eff != '0)
                        begin
                            // literal data byte passes through
                            lit_next   = lit_eff - pld_pkg::LEN_W'(1);
                            byte_next  = comp.data.in_byte;
                            state_next = pld_pkg::ST_LIT;
                        end
                        else if (ctl_mode == pld_pkg::MODE_LITERAL)
                        begin
                            if (ctl_len == '0 || last)
                                state_next = pld_pkg::ST_DONE;   // end marker
                            else
                                lit_next = ctl_len;
                        end
                        else
                        begin
                            mode_next = ctl_mode;
                            len_next  = ctl_len;
                            if (ctl_len != '0)
                                state_next = pld_pkg::ST_COPY_RD;
                            else if (last)
                                state_next = pld_pkg::ST_DONE;
                        end
                    end
                end
            end

            pld_pkg::ST_COPY_RD:
            begin
                // source outside the decoded range or offset not negative reads 0
                rd_en      = 1'b1;
                zero_next  = !raw_off[pld_pkg::OFFSET_W-1]
                           || (pld_pkg::COUNT_W'(back_dist) > cnt_reg);
                state_next = pld_pkg::ST_COPY_WR;
            end

            pld_pkg::ST_COPY_WR, pld_pkg::ST_LIT:
            begin
                if (out_free)
                begin
                    mem_we                      = 1'b1;
                    out_valid_next              = 1'b1;
                    out_data_next.out_byte      = emit_byte;
                    out_data_next.byte_valid    = 1'b1;
                    out_data_next.image_done    = 1'b0;
                    out_data_next.bytes_written = '0;
                    out_data_next.run_last      = last_byte && !pend_reg;
                    wp_next                     = wp_reg + pld_pkg::PTR_W'(1);
                    if (cnt_reg != pld_pkg::COUNT_MAX)
                        cnt_next = cnt_reg + pld_pkg::COUNT_W'(1);
                    len_next = len_reg - pld_pkg::LEN_W'(1);
                    if (last_byte)
                        state_next = pend_reg ? pld_pkg::ST_DONE : pld_pkg::ST_IDLE;
                    else
                        state_next = pld_pkg::ST_COPY_RD;
                end
            end

            pld_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.out_byte      = '0;
                    out_data_next.byte_valid    = 1'b0;
                    out_data_next.image_done    = 1'b1;
                    out_data_next.bytes_written = cnt_reg;
                    out_data_next.run_last      = 1'b1;
                    fin_next                    = 1'b1;
                    lit_next                    = '0;
                    state_next                  = pld_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pld_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pld_pkg::ST_IDLE;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            lit_reg       <= '0;
            fin_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            lit_reg       <= lit_next;
            fin_reg       <= fin_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        mode_reg     <= mode_next;
        byte_reg     <= byte_next;
        zero_reg     <= zero_next;
        out_data_reg <= out_data_next;
    end

    // Offset registers; indexes past the last mode are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pld_pkg::NUM_OFFSETS; i++)
                offset_reg[i] <= '1;
        end
        else if (cfg_we && (cfg_index < pld_pkg::CFG_IDX_W'(pld_pkg::NUM_OFFSETS)))
        begin
            offset_reg[cfg_index] <= cfg_data;
        end
    end

    // History ring: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            history_mem[wp_reg] <= emit_byte;
        if (rd_en)
            rd_data_reg <= history_mem[rd_addr];
    end

endmodule
`default_nettype wire

[sv/pld_checker.sv]
// pld_checker: port-level assertions for the predictive LZ image decoder,
// bound to the top level. Depends on pld_pkg and predictive_lz_image_decoder.
`timescale 1ns / 1ps
`default_nettype none
module pld_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire pld_pkg::out_req_t out_data
);

    // Stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output request changed");

    // Done request carries no byte and closes the input's results
    a_done_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.image_done |-> !out_data.byte_valid && out_data.run_last)
        else $error("malformed done request");

    // Byte requests carry no count
    a_byte_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.byte_valid
            |-> !out_data.image_done && (out_data.bytes_written == '0))
        else $error("malformed byte request");

    // More results pending, so no new input
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.run_last |-> !in_ready)
        else $error("input ready while results of an input are pending");

endmodule

bind predictive_lz_image_decoder pld_checker u_pld_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (comp.ready),
    .out_valid (decomp.valid),
    .out_ready (decomp.ready),
    .out_data  (decomp.data)
);
`default_nettype wire
